[rtl/sfan_pkg.sv]
// Shared types, register indexes and sequencing constants for the seat frame normalizer.
package sfan_pkg;

    localparam int POSITION_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_AXES   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_SCALE      = 2'd2;

    localparam logic signed [CFG_DATA_W-1:0] SCALE_RESET = 32'sd65536;

    localparam logic [15:0] LEVEL_NEUTRAL = 16'd16384;
    localparam logic [15:0] LEVEL_MAX     = 16'd32768;

    // Multiply step sequence: six cross products, nine dot products, three gains.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_CROSS    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DOT_FWD  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_DOT_LEFT = 5'd9;
    localparam logic [STEP_W-1:0] STEP_DOT_UP   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_LEVEL    = 5'd15;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd17;

    typedef struct packed {
        logic               frame_valid;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0] forward_level;
        logic [15:0] left_level;
        logic [15:0] up_level;
    } t_out_item;

    typedef struct packed {
        logic              load;
        logic              neutral;
        logic              vel;
        logic              acc;
        logic              mac_en;
        logic [STEP_W-1:0] step;
        logic              push;
        logic              commit;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VEL,
        ST_ACC,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

[rtl/seat_frame_acceleration_normalizer_core.sv]
// Top level of the seat frame acceleration normalizer.
// One frame is taken at a time. A valid frame runs through ST_VEL and ST_ACC for saturating
// velocity and acceleration differences, then eighteen products through the single shared
// multiplier (six for the left axis, nine for the three projections, three for the gains),
// ST_DRAIN to drain the accumulator and ST_OUT to load the output register. A frame with
// frame_valid low sets 0.5 on all levels at acceptance and goes straight to ST_OUT. The
// output register loads only once the previous result has been taken, so an output stall
// holds the frame in its last cycle and the input waits with it.
// The next frame is accepted as soon as the result has moved to the output register, even
// while that result still waits to be taken. Scale registers are written through the plain
// write port; the user must write them only while no frame is in work, since the block
// itself does not enforce it.
module seat_frame_acceleration_normalizer_core
    import sfan_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;

    sfan_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_frame_valid (i_in_data.frame_valid),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd         (w_cmd)
    );

    sfan_dp #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out       (o_out_data)
    );

endmodule

[rtl/sfan_ctrl.sv]
// Sequencer for the seat frame normalizer: request handshakes and multiply step order.
module sfan_ctrl
    import sfan_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_frame_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_frame, n_frame;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_frame     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_frame     = r_frame;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_frame    = i_frame_valid;
                    if (i_frame_valid) begin
                        n_state = ST_VEL;
                    end else begin
                        o_cmd.neutral = 1'b1;
                        n_state       = ST_OUT;
                    end
                end
            end
            ST_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = STEP_CROSS;
                n_state   = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.step   = r_step;
                if (r_step == STEP_LAST) begin
                    n_step  = STEP_CROSS;
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last gain product lands in the level registers here
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.commit = r_frame;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted request did not start work");

    a_step_only_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_CROSS) |-> (r_state == ST_MAC))
        else $error("step counter running outside multiply phase");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside output state");

    a_commit_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> ($past(r_state, 2) == ST_DRAIN || $past(r_state) == ST_DRAIN
                          || $past(r_state) == ST_OUT))
        else $error("state update without a finished frame");

endmodule

[rtl/sfan_dp.sv]
// Datapath: frame capture, saturating differences, shared multiplier and accumulator.
module sfan_dp
    import sfan_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_in_item              i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_out_item             o_out
);

    localparam int PW   = POSITION_WIDTH;
    localparam int AW   = (PW > 32) ? PW : 32;
    localparam int PW_P = AW + 32;
    localparam int SUMW = (PW + 4 > 34) ? PW + 4 : 34;

    localparam logic signed [AW-1:0]   POS_HI = (AW'(1) <<< (PW - 1)) - AW'(1);
    localparam logic signed [AW-1:0]   POS_LO = -POS_HI - AW'(1);
    localparam logic signed [SUMW-1:0] DOT_HI = (SUMW'(1) <<< 31) - SUMW'(1);
    localparam logic signed [SUMW-1:0] DOT_LO = -DOT_HI - SUMW'(1);
    localparam logic signed [SUMW-1:0] AX_HI  = SUMW'(32767);
    localparam logic signed [SUMW-1:0] AX_LO  = -AX_HI - SUMW'(1);
    localparam logic signed [PW_P-1:0] LV_MAX = PW_P'(32768);
    localparam logic signed [PW_P-1:0] LV_OFS = PW_P'(16384);

    function automatic logic signed [PW-1:0] sat_diff(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b
    );
        logic signed [PW:0] d;
        d = (PW+1)'(a) - (PW+1)'(b);
        if (d[PW] != d[PW-1]) begin
            return d[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        return d[PW-1:0];
    endfunction

    logic signed [PW-1:0]         r_pos      [NUM_AXES];
    logic signed [15:0]           r_fwd      [NUM_AXES];
    logic signed [15:0]           r_up       [NUM_AXES];
    logic signed [15:0]           r_left     [NUM_AXES];
    logic signed [PW-1:0]         r_vel      [NUM_AXES];
    logic signed [PW-1:0]         r_acc      [NUM_AXES];
    logic signed [PW-1:0]         r_last_pos [NUM_AXES];
    logic signed [PW-1:0]         r_last_vel [NUM_AXES];
    logic signed [CFG_DATA_W-1:0] r_scale    [NUM_AXES];
    logic signed [31:0]           r_dot      [NUM_AXES];
    logic [15:0]                  r_level    [NUM_AXES];
    logic signed [PW_P-1:0]       r_prod;
    logic [STEP_W-1:0]            r_pstep;
    logic                         r_ptag_valid;
    logic signed [SUMW-1:0]       r_sum;
    t_out_item                    r_out;

    logic signed [31:0]     w_pos_in [NUM_AXES];
    logic signed [AW-1:0]   w_pos_ext [NUM_AXES];
    logic signed [PW-1:0]   w_pos_sat [NUM_AXES];
    logic signed [AW-1:0]   w_mul_a;
    logic signed [31:0]     w_mul_b;
    logic signed [PW_P-1:0] w_prod;
    logic signed [SUMW-1:0] w_p_cross;
    logic signed [SUMW-1:0] w_p_sh;
    logic signed [SUMW-1:0] w_cross_f;
    logic signed [SUMW-1:0] w_dot_t;
    logic signed [15:0]     w_left_sat;
    logic signed [31:0]     w_dot_sat;
    logic signed [PW_P-1:0] w_lvl_v;
    logic [15:0]            w_lvl;

    // input positions, saturated (or sign extended) to the state width
    always_comb begin
        w_pos_in[0] = i_in.pos_x;
        w_pos_in[1] = i_in.pos_y;
        w_pos_in[2] = i_in.pos_z;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_pos_ext[i] = AW'(w_pos_in[i]);
            if (w_pos_ext[i] > POS_HI) begin
                w_pos_sat[i] = PW'(POS_HI);
            end else if (w_pos_ext[i] < POS_LO) begin
                w_pos_sat[i] = PW'(POS_LO);
            end else begin
                w_pos_sat[i] = PW'(w_pos_ext[i]);
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.step)
            STEP_CROSS:              begin w_mul_a = AW'(r_up[1]);  w_mul_b = 32'(r_fwd[2]); end
            STEP_CROSS + 5'd1:       begin w_mul_a = AW'(r_up[2]);  w_mul_b = 32'(r_fwd[1]); end
            STEP_CROSS + 5'd2:       begin w_mul_a = AW'(r_up[2]);  w_mul_b = 32'(r_fwd[0]); end
            STEP_CROSS + 5'd3:       begin w_mul_a = AW'(r_up[0]);  w_mul_b = 32'(r_fwd[2]); end
            STEP_CROSS + 5'd4:       begin w_mul_a = AW'(r_up[0]);  w_mul_b = 32'(r_fwd[1]); end
            STEP_CROSS + 5'd5:       begin w_mul_a = AW'(r_up[1]);  w_mul_b = 32'(r_fwd[0]); end
            STEP_DOT_FWD:            begin w_mul_a = AW'(r_acc[0]); w_mul_b = 32'(r_fwd[0]); end
            STEP_DOT_FWD + 5'd1:     begin w_mul_a = AW'(r_acc[1]); w_mul_b = 32'(r_fwd[1]); end
            STEP_DOT_FWD + 5'd2:     begin w_mul_a = AW'(r_acc[2]); w_mul_b = 32'(r_fwd[2]); end
            STEP_DOT_LEFT:           begin w_mul_a = AW'(r_acc[0]); w_mul_b = 32'(r_left[0]); end
            STEP_DOT_LEFT + 5'd1:    begin w_mul_a = AW'(r_acc[1]); w_mul_b = 32'(r_left[1]); end
            STEP_DOT_LEFT + 5'd2:    begin w_mul_a = AW'(r_acc[2]); w_mul_b = 32'(r_left[2]); end
            STEP_DOT_UP:             begin w_mul_a = AW'(r_acc[0]); w_mul_b = 32'(r_up[0]); end
            STEP_DOT_UP + 5'd1:      begin w_mul_a = AW'(r_acc[1]); w_mul_b = 32'(r_up[1]); end
            STEP_DOT_UP + 5'd2:      begin w_mul_a = AW'(r_acc[2]); w_mul_b = 32'(r_up[2]); end
            STEP_LEVEL:              begin w_mul_a = AW'(r_dot[0]); w_mul_b = r_scale[0]; end
            STEP_LEVEL + 5'd1:       begin w_mul_a = AW'(r_dot[1]); w_mul_b = r_scale[1]; end
            STEP_LEVEL + 5'd2:       begin w_mul_a = AW'(r_dot[2]); w_mul_b = r_scale[2]; end
            default:                 begin w_mul_a = '0;            w_mul_b = '0; end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // accumulate side, fed from the registered multiplier product
    always_comb begin
        w_p_cross = SUMW'(r_prod);
        w_p_sh    = SUMW'(r_prod >>> 14);
        w_cross_f = (r_sum - w_p_cross) >>> 14;
        w_dot_t   = r_sum + w_p_sh;
        w_lvl_v   = (r_prod >>> 17) + LV_OFS;

        if (w_cross_f > AX_HI) begin
            w_left_sat = 16'sh7fff;
        end else if (w_cross_f < AX_LO) begin
            w_left_sat = 16'sh8000;
        end else begin
            w_left_sat = 16'(w_cross_f);
        end

        if (w_dot_t > DOT_HI) begin
            w_dot_sat = 32'sh7fff_ffff;
        end else if (w_dot_t < DOT_LO) begin
            w_dot_sat = 32'sh8000_0000;
        end else begin
            w_dot_sat = 32'(w_dot_t);
        end

        if (w_lvl_v < 0) begin
            w_lvl = '0;
        end else if (w_lvl_v > LV_MAX) begin
            w_lvl = LEVEL_MAX;
        end else begin
            w_lvl = 16'(w_lvl_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag_valid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_scale[i]    <= SCALE_RESET;
                r_last_pos[i] <= '0;
                r_last_vel[i] <= '0;
            end
        end else begin
            r_ptag_valid <= i_cmd.mac_en;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FORWARD_SCALE: r_scale[0] <= i_cfg_wdata;
                    CFG_LEFT_SCALE:    r_scale[1] <= i_cfg_wdata;
                    CFG_UP_SCALE:      r_scale[2] <= i_cfg_wdata;
                    default:           ;
                endcase
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_last_pos[i] <= r_pos[i];
                    r_last_vel[i] <= r_vel[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= w_pos_sat;
            r_fwd[0] <= i_in.fwd_x;
            r_fwd[1] <= i_in.fwd_y;
            r_fwd[2] <= i_in.fwd_z;
            r_up[0]  <= i_in.up_x;
            r_up[1]  <= i_in.up_y;
            r_up[2]  <= i_in.up_z;
        end
        if (i_cmd.neutral) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_level[i] <= LEVEL_NEUTRAL;
            end
        end
        if (i_cmd.vel) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_vel[i] <= sat_diff(r_pos[i], r_last_pos[i]);
            end
        end
        if (i_cmd.acc) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_acc[i] <= sat_diff(r_vel[i], r_last_vel[i]);
            end
        end

        r_prod  <= w_prod;
        r_pstep <= i_cmd.step;

        if (r_ptag_valid) begin
            unique case (r_pstep) inside
                STEP_CROSS, STEP_CROSS + 5'd2, STEP_CROSS + 5'd4: r_sum <= w_p_cross;
                STEP_CROSS + 5'd1:    r_left[0] <= w_left_sat;
                STEP_CROSS + 5'd3:    r_left[1] <= w_left_sat;
                STEP_CROSS + 5'd5:    r_left[2] <= w_left_sat;
                STEP_DOT_FWD, STEP_DOT_LEFT, STEP_DOT_UP: r_sum <= w_p_sh;
                STEP_DOT_FWD + 5'd1, STEP_DOT_LEFT + 5'd1, STEP_DOT_UP + 5'd1: r_sum <= w_dot_t;
                STEP_DOT_FWD + 5'd2:  r_dot[0] <= w_dot_sat;
                STEP_DOT_LEFT + 5'd2: r_dot[1] <= w_dot_sat;
                STEP_DOT_UP + 5'd2:   r_dot[2] <= w_dot_sat;
                STEP_LEVEL:           r_level[0] <= w_lvl;
                STEP_LEVEL + 5'd1:    r_level[1] <= w_lvl;
                STEP_LEVEL + 5'd2:    r_level[2] <= w_lvl;
                default:              ;
            endcase
        end

        if (i_cmd.push) begin
            r_out.forward_level <= r_level[0];
            r_out.left_level    <= r_level[1];
            r_out.up_level      <= r_level[2];
        end
    end

    assign o_out = r_out;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_level[0] <= LEVEL_MAX && r_level[1] <= LEVEL_MAX
                        && r_level[2] <= LEVEL_MAX))
        else $error("level outside unit range");

    a_commit_not_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && (i_cmd.load || i_cmd.mac_en)))
        else $error("state update overlaps active work");

endmodule
